// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cabh_pkg.sv =====
// ---------------------------------------------------------------------------
// CRC-32 augmented byte hash package
// Widths, reset constants and the per-byte CRC term shared by the block.
// ---------------------------------------------------------------------------
package cabh_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  localparam crc_t CrcPolyReset = 32'h04C1_1DB7;
  localparam crc_t CrcTopBit    = 32'h8000_0000;
  localparam crc_t CrcZero      = '0;

  // Top byte placed in the high end and run through eight polynomial steps.
  function automatic crc_t crc_top_term(input byte_t top, input crc_t poly);
    crc_t v;
    v = {top, {(CrcWidth - ByteWidth){1'b0}}};
    for (int k = 0; k < ByteWidth; k++) begin
      if ((v & CrcTopBit) != CrcZero) begin
        v = (v << 1) ^ poly;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

// ===== hdl/cabh_byte_update.sv =====
// ---------------------------------------------------------------------------
// CRC byte update
// Shifts one message byte into the low end of the CRC register and folds in
// the polynomial term of the byte that leaves the top.
// ---------------------------------------------------------------------------
module cabh_byte_update (
  input  cabh_pkg::crc_t  crc_i,
  input  cabh_pkg::byte_t byte_i,
  input  cabh_pkg::crc_t  poly_i,
  output cabh_pkg::crc_t  crc_o
);
  import cabh_pkg::*;

  assign crc_o = crc_top_term(crc_i[CrcWidth-1 -: ByteWidth], poly_i)
               ^ {crc_i[CrcWidth-ByteWidth-1:0], byte_i};

endmodule

// ===== hdl/crc32_augmented_byte_hash_top.sv =====
// ---------------------------------------------------------------------------
// CRC-32 augmented byte hash
// Top level: input register, byte update, CRC state and result register.
// ---------------------------------------------------------------------------
// Each request on the s_axis channel carries one message byte. tuser bit 0
// says whether the byte is present, tuser bit 1 clears the CRC register to
// zero before the byte, and tlast closes the message. For each request with
// tlast set, one request leaves on m_axis with the inverted CRC register in
// tdata and a zero flag in tuser; other requests produce no output.
// A request is registered in the input register on acceptance and processed
// from there; a closing request's result then goes into the result register,
// which holds it until it is taken. One request is accepted every cycle while
// the processing stage is not waiting for the result register; the single CRC
// update per cycle in the byte update stage sets that figure.
// When the receiver stalls, the pending result is held in the result
// register and input keeps flowing until a second closing request reaches
// the processing stage, which then waits for the result register to free.
// Reset clears the CRC register, loads the polynomial with 0x04C11DB7 and
// empties both stages. The cfg channel is always ready and should be written
// only while no request is in flight.
// ---------------------------------------------------------------------------
module crc32_augmented_byte_hash_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i,      // polynomial
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,    // data_byte
  input  logic [1:0]            s_axis_tuser,    // byte_present, first_of_message
  input  logic                  s_axis_tlast,    // last_of_message
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,    // hash_value
  output logic                  m_axis_tuser     // hash_is_zero
);
  import cabh_pkg::*;

  crc_t  poly_q, poly_d;
  crc_t  crc_q, crc_d;
  logic  in_valid_q, in_valid_d;
  byte_t in_byte_q;
  logic  in_present_q, in_first_q, in_last_q;
  logic  out_valid_q, out_valid_d;
  crc_t  out_hash_q;
  logic  out_zero_q;

  crc_t  crc_cur, crc_upd, crc_next, hash_next;
  logic  in_accept, out_free, stage_adv, out_load;

  assign cfg_ready_o = 1'b1;
  assign poly_d      = (cfg_valid_i) ? cfg_data_i : poly_q;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign stage_adv     = in_valid_q && (!in_last_q || out_free);
  assign out_load      = stage_adv && in_last_q;
  assign s_axis_tready = !in_valid_q || stage_adv;

  assign crc_cur = in_first_q ? CrcZero : crc_q;

  cabh_byte_update u_byte_update (
    .crc_i  (crc_cur),
    .byte_i (in_byte_q),
    .poly_i (poly_q),
    .crc_o  (crc_upd)
  );

  assign crc_next  = in_present_q ? crc_upd : crc_cur;
  assign hash_next = ~crc_next;

  always_comb begin
    crc_d       = stage_adv ? crc_next : crc_q;
    in_valid_d  = in_accept || (in_valid_q && !stage_adv);
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q      <= CrcPolyReset;
      crc_q       <= CrcZero;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      poly_q      <= poly_d;
      crc_q       <= crc_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q    <= s_axis_tdata;
      in_present_q <= s_axis_tuser[0];
      in_first_q   <= s_axis_tuser[1];
      in_last_q    <= s_axis_tlast;
    end
    if (out_load) begin
      out_hash_q <= hash_next;
      out_zero_q <= (hash_next == CrcZero);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_hash_q;
  assign m_axis_tuser  = out_zero_q;

endmodule

// ===== hdl/cabh_checker.sv =====
// ---------------------------------------------------------------------------
// CRC-32 augmented byte hash checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cabh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `ASSERT_CLK(a_zero_flag, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == 32'h0)), "zero flag disagrees with hash")
  `ASSERT_CLK(a_result_from_last, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "result without a closing request")
  `ASSERT_CLK(a_valid_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_data_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind crc32_augmented_byte_hash_top cabh_checker u_cabh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// CRC-32 augmented byte hash testbench
// Streams messages through the hash block under random sender and receiver
// idling and compares every hash against a bit-serial CRC predictor. Covers
// empty messages, absent bytes, continuation without a clear, polynomial
// extremes, a polynomial change inside a message and a long receiver stall.
// ---------------------------------------------------------------------------
module tb;
  import cabh_pkg::*;

  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned WatchdogLimit = 4000;

  typedef struct packed {
    crc_t value;
    logic is_zero;
  } hash_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  crc_t         model_crc  = CrcZero;
  crc_t         model_poly = CrcPolyReset;
  hash_result_t pending_hashes[$];

  bit          no_idle       = 1'b0;
  int unsigned hold_request  = 0;
  int unsigned requests_sent = 0;
  int unsigned hashes_seen   = 0;
  int unsigned poly_settings = 0;
  int unsigned zero_hashes   = 0;
  int unsigned fail_count    = 0;

  crc32_augmented_byte_hash_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The byte is clocked in one bit at a time from its top bit, which gives
  // the same register as the top-byte term XORed with the shifted register.
  function automatic crc_t crc_shift_byte(input crc_t crc, input byte_t data,
                                          input crc_t poly);
    crc_t r;
    logic msb;
    r = crc;
    for (int i = ByteWidth - 1; i >= 0; i--) begin
      msb = r[CrcWidth-1];
      r   = {r[CrcWidth-2:0], data[i]};
      if (msb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  function automatic void track_request(input byte_t data, input bit present,
                                        input bit first, input bit last);
    hash_result_t res;
    if (first) begin
      model_crc = CrcZero;
    end
    if (present) begin
      model_crc = crc_shift_byte(model_crc, data, model_poly);
    end
    if (last) begin
      res.value   = ~model_crc;
      res.is_zero = (res.value == CrcZero);
      pending_hashes.push_back(res);
    end
  endfunction

  task automatic send_request(input byte_t data, input bit present, input bit first,
                              input bit last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= {first, present};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_request(data, present, first, last);
    requests_sent++;
  endtask

  // Requests without a closing mark leave nothing to wait for, so a settle
  // wait lets the processing stage empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_polynomial(input crc_t poly);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= poly;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_poly = poly;
    poly_settings++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_request(byte_t'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (r < 18) begin
        send_request(byte_t'($urandom), 1'b0, 1'b1, 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_request(byte_t'($urandom), $urandom_range(0, 9) != 0,
                       (r >= 22) && (i == 0), i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  task automatic test_message_forms();
    byte_t digits[4] = '{8'h31, 8'h32, 8'h33, 8'h34};
    write_polynomial(CrcPolyReset);
    send_request(8'hA5, 1'b0, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) begin
      send_request(digits[i], 1'b1, i == 0, 1'b0);
    end
    send_request(8'h5A, 1'b0, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0, 1'b1);
    send_request(8'h01, 1'b1, 1'b0, 1'b0);
    send_request(8'h7F, 1'b1, 1'b0, 1'b1);
    send_request(8'hC3, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_polynomial_change_mid_message();
    send_request(8'h12, 1'b1, 1'b1, 1'b0);
    send_request(8'h34, 1'b1, 1'b0, 1'b0);
    write_polynomial(32'hEDB8_8320);
    send_request(8'h56, 1'b1, 1'b0, 1'b1);
  endtask

  // With a zero polynomial the register is a plain byte shifter, so four
  // all-ones bytes leave it all ones and the hash becomes zero.
  task automatic test_zero_hash();
    write_polynomial(CrcZero);
    for (int i = 0; i < 4; i++) begin
      send_request(8'hFF, 1'b1, i == 0, i == 3);
    end
    write_polynomial(32'hFFFF_FFFF);
    send_request(8'hFF, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_random_polynomials();
    crc_t polys[5];
    polys = '{CrcPolyReset, CrcZero, 32'hFFFF_FFFF, 32'h1EDC_6F41, crc_t'($urandom)};
    foreach (polys[i]) begin
      write_polynomial(polys[i]);
      send_random_traffic(250);
    end
  endtask

  task automatic test_back_pressure();
    drain();
    hold_request = HoldCycles;
    no_idle      = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_request(byte_t'($urandom), 1'b1, ($urandom_range(0, 3) == 0), 1'b1);
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_full_rate();
    write_polynomial(CrcPolyReset);
    no_idle = 1'b1;
    send_random_traffic(60);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_message_forms();
    test_polynomial_change_mid_message();
    test_zero_hash();
    test_random_polynomials();
    test_back_pressure();
    test_full_rate();
    drain();
    $display("Sent %0d requests over %0d polynomial settings; checked %0d hashes.",
             requests_sent, poly_settings, hashes_seen);
    $display("Zero hashes seen: %0d; receiver held off once for %0d cycles.",
             zero_hashes, HoldCycles);
    if (fail_count == 0 && pending_hashes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    hash_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        hashes_seen++;
        if (pending_hashes.size() == 0) begin
          $error("Unexpected hash_value %h with no request waiting", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_hashes.pop_front();
          if (want.is_zero) begin
            zero_hashes++;
          end
          if (m_axis_tdata !== want.value) begin
            $error("hash_value: expected %h, got %h", want.value, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.is_zero) begin
            $error("hash_is_zero: expected %b, got %b", want.is_zero, m_axis_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout after %0d cycles without a handshake", WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
